// ===== hdl/srf_pkg.sv =====
// shared types, constants and helpers of the scalar register file
package srf_pkg;

   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 8;
   localparam int LANE_W     = 6;
   localparam int REG_COUNT  = 256;
   localparam int HALF_LANES = 32;
   localparam int BIT_W      = $clog2(HALF_LANES);

   // special register indices
   localparam logic [ADDR_W-1:0] VCC_INDEX   = 8'd106;
   localparam logic [ADDR_W-1:0] EXEC_INDEX  = 8'd126;
   localparam logic [ADDR_W-1:0] VCCZ_INDEX  = 8'd251;
   localparam logic [ADDR_W-1:0] EXECZ_INDEX = 8'd252;

   // command codes
   typedef enum logic [1:0] {
      CMD_READ      = 2'd0,
      CMD_WRITE     = 2'd1,
      CMD_SET_LANE  = 2'd2,
      CMD_READ_LANE = 2'd3
   } cmd_type;

   // reserved index check, one bit wider than the file so that the
   // upper half of a pair at the last index also counts as reserved
   function automatic logic is_reserved(input logic [ADDR_W:0] idx);
      logic res;
      res = 1'b0;
      if (idx[ADDR_W]) begin
         res = 1'b1;
      end else begin
         case (idx[ADDR_W-1:0]) inside
            8'd104, 8'd105, 8'd125, 8'd254: res = 1'b1;
            [8'd209:8'd239]:                res = 1'b1;
            [8'd248:8'd250]:                res = 1'b1;
            default:                        res = 1'b0;
         endcase
      end
      return res;
   endfunction

endpackage

// ===== hdl/srf_req_if.sv =====
// command channel of the scalar register file
interface srf_req_if import srf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [ADDR_W-1:0]   reg_index;
   logic [DATA_W-1:0]   write_value;
   logic [LANE_W-1:0]   lane;

   modport source (output valid, output cmd, output reg_index, output write_value,
                   output lane, input ready);
   modport sink   (input valid, input cmd, input reg_index, input write_value,
                   input lane, output ready);
endinterface

// response channel of the scalar register file
interface srf_rsp_if import srf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic                lane_value;
   logic                illegal;

   modport source (output valid, output read_data, output lane_value, output illegal,
                   input ready);
   modport sink   (input valid, input read_data, input lane_value, input illegal,
                   output ready);
endinterface

// ===== hdl/srf_ram.sv =====
// generic single write port ram with registered read
module srf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/scalar_register_file_lane_mask.sv =====
// top level of the scalar register file with lane mask access and zero flags
//
// Commands enter on req_bus: read a register, write a register, set or
// clear one lane bit of a 64-bit mask pair, or read one lane bit. Lanes
// 0-31 address the given register, lanes 32-63 the next one. Every command
// gives exactly one beat on rsp_bus with read_data, lane_value and illegal.
// Reads of the VCCZ and EXECZ indices return the zero flag derived from
// the current VCC or EXEC pair. A reserved index sets illegal and blocks
// the write.
// The command and the ram read are registered; the read-modify-write and
// zero flag logic sit in front of the response register. One command is
// taken per cycle while rsp_bus is not stalled; a write from the previous
// command is forwarded to a read of the same index in the next cycle.
// Reset is synchronous: all registers read as zero and both zero flags as
// one, through per-entry valid bits and the pair state; no clearing pass
// is needed.
// When rsp_bus stalls, the response register holds and req_bus.ready
// drops once the command stage is full as well.
module scalar_register_file_lane_mask import srf_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   srf_req_if.sink   req_bus,
   srf_rsp_if.source rsp_bus
);

   localparam logic [ADDR_W-1:0] VCC_HI_INDEX  = ADDR_W'(VCC_INDEX + 1);
   localparam logic [ADDR_W-1:0] EXEC_HI_INDEX = ADDR_W'(EXEC_INDEX + 1);

   // command stage
   logic                s1_valid_ff, s1_valid_in;
   cmd_type             s1_cmd_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [DATA_W-1:0]   s1_val_ff;
   logic [BIT_W-1:0]    s1_bit_ff;
   logic                s1_illegal_ff;

   // write forwarding and entry valid bits
   logic                fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]   fwd_addr_ff;
   logic [DATA_W-1:0]   fwd_data_ff;
   logic [REG_COUNT-1:0] valid_bits_ff, valid_bits_in;

   // nonzero state of the mask pair halves
   logic vcc_lo_nz_ff, vcc_lo_nz_in, vcc_hi_nz_ff, vcc_hi_nz_in;
   logic exec_lo_nz_ff, exec_lo_nz_in, exec_hi_nz_ff, exec_hi_nz_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_lane_ff, rsp_lane_in;
   logic                rsp_illegal_ff, rsp_illegal_in;

   logic                accept;
   logic                s1_adv;
   logic [ADDR_W:0]     req_addr;
   logic [DATA_W-1:0]   ram_q;
   logic [DATA_W-1:0]   raw_word;
   logic [DATA_W-1:0]   cur_word;
   logic [DATA_W-1:0]   lane_mask;
   logic [DATA_W-1:0]   new_word;
   logic                do_write;
   logic                vccz, execz;

   // handshake
   assign s1_adv        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;

   // target index: upper lanes move to the next register
   assign req_addr = {1'b0, req_bus.reg_index}
                   + (ADDR_W+1)'(req_bus.cmd[1] && req_bus.lane[LANE_W-1]);

   srf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (s1_addr_ff),
      .wr_data (new_word),
      .rd_en   (accept),
      .rd_addr (req_addr[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   // current word: forwarded write, stored entry or reset value
   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) begin
         raw_word = fwd_data_ff;
      end else if (valid_bits_ff[s1_addr_ff]) begin
         raw_word = ram_q;
      end else begin
         raw_word = '0;
      end
   end

   assign vccz  = !vcc_lo_nz_ff && !vcc_hi_nz_ff;
   assign execz = !exec_lo_nz_ff && !exec_hi_nz_ff;

   // zero flag indices read the derived flag
   always_comb begin
      if (s1_addr_ff == VCCZ_INDEX) begin
         cur_word = DATA_W'(vccz);
      end else if (s1_addr_ff == EXECZ_INDEX) begin
         cur_word = DATA_W'(execz);
      end else begin
         cur_word = raw_word;
      end
   end

   // modify step
   assign lane_mask = DATA_W'(1) << s1_bit_ff;

   always_comb begin
      if (s1_cmd_ff == CMD_WRITE) begin
         new_word = s1_val_ff;
      end else if (s1_val_ff != '0) begin
         new_word = cur_word | lane_mask;
      end else begin
         new_word = cur_word & ~lane_mask;
      end
   end

   assign do_write = s1_valid_ff && s1_adv && !s1_illegal_ff
                  && (s1_cmd_ff == CMD_WRITE || s1_cmd_ff == CMD_SET_LANE);

   // next state of the control and tracking registers
   always_comb begin
      s1_valid_in   = accept || (s1_valid_ff && !s1_adv);
      fwd_valid_in  = fwd_valid_ff || do_write;
      valid_bits_in = valid_bits_ff;
      vcc_lo_nz_in  = vcc_lo_nz_ff;
      vcc_hi_nz_in  = vcc_hi_nz_ff;
      exec_lo_nz_in = exec_lo_nz_ff;
      exec_hi_nz_in = exec_hi_nz_ff;
      if (do_write) begin
         valid_bits_in[s1_addr_ff] = 1'b1;
         if (s1_addr_ff == VCC_INDEX)     vcc_lo_nz_in  = (new_word != '0);
         if (s1_addr_ff == VCC_HI_INDEX)  vcc_hi_nz_in  = (new_word != '0);
         if (s1_addr_ff == EXEC_INDEX)    exec_lo_nz_in = (new_word != '0);
         if (s1_addr_ff == EXEC_HI_INDEX) exec_hi_nz_in = (new_word != '0);
      end
   end

   // response fields
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_lane_in    = rsp_lane_ff;
      rsp_illegal_in = rsp_illegal_ff;
      if (s1_adv) begin
         rsp_valid_in   = s1_valid_ff;
         rsp_illegal_in = s1_illegal_ff;
         rsp_data_in    = (!s1_illegal_ff && s1_cmd_ff == CMD_READ) ? cur_word : '0;
         rsp_lane_in    = !s1_illegal_ff && s1_cmd_ff == CMD_READ_LANE
                          && cur_word[s1_bit_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         valid_bits_ff <= '0;
         vcc_lo_nz_ff  <= 1'b0;
         vcc_hi_nz_ff  <= 1'b0;
         exec_lo_nz_ff <= 1'b0;
         exec_hi_nz_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         valid_bits_ff <= valid_bits_in;
         vcc_lo_nz_ff  <= vcc_lo_nz_in;
         vcc_hi_nz_ff  <= vcc_hi_nz_in;
         exec_lo_nz_ff <= exec_lo_nz_in;
         exec_hi_nz_ff <= exec_hi_nz_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= cmd_type'(req_bus.cmd);
         s1_addr_ff    <= req_addr[ADDR_W-1:0];
         s1_val_ff     <= req_bus.write_value;
         s1_bit_ff     <= req_bus.lane[BIT_W-1:0];
         s1_illegal_ff <= is_reserved(req_addr);
      end
      if (do_write) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_word;
      end
      rsp_data_ff    <= rsp_data_in;
      rsp_lane_ff    <= rsp_lane_in;
      rsp_illegal_ff <= rsp_illegal_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = rsp_data_ff;
   assign rsp_bus.lane_value = rsp_lane_ff;
   assign rsp_bus.illegal    = rsp_illegal_ff;

endmodule
